[sv/wchs_pkg.sv]
// Shared types, constants and arithmetic helpers of the Welch H1 block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package wchs_pkg;

    localparam int FFT_SIZE_DEF = 1024;
    localparam int BIN_W        = 10;
    localparam int SPEC_W       = 24;
    localparam int SUM_W        = 64;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;

    // input kinds
    localparam logic [1:0] KIND_ACC    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_REGZ  = 1'b1;

    localparam logic [23:0] SCALE_RESET = 24'd65536;
    localparam logic [31:0] REGZ_RESET  = 32'd0;

    // classified commands that travel through the queue
    typedef enum logic [1:0] {
        CMD_ACC,
        CMD_READ,
        CMD_READ_OOR,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [BIN_W-1:0]         bin;
        logic                     seg_end;
        logic                     band_end;
        logic signed [SPEC_W-1:0] u_re;
        logic signed [SPEC_W-1:0] u_im;
        logic signed [SPEC_W-1:0] y_re;
        logic signed [SPEC_W-1:0] y_im;
    } qent_t;

    // magnitude of a signed 64-bit value
    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? 64'(-x) : 64'(x);
    endfunction

    // saturating add of a 49-bit term to a 64-bit sum
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [48:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + 65'(b);
        if (s[64] != s[63]) begin
            sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    // Q16.16 gain from an unsigned quotient and the numerator sign
    function automatic logic [31:0] gain_fix(input logic [79:0] q, input logic neg);
        logic        over;
        logic [31:0] m;
        over = |q[79:31];
        m    = over ? 32'h8000_0000 : {1'b0, q[30:0]};
        if (neg) begin
            gain_fix = 32'(-m);
        end else begin
            gain_fix = over ? 32'h7FFF_FFFF : m;
        end
    endfunction

endpackage
`default_nettype wire

[sv/wchs_front.sv]
// Front end: accepts input beats, classifies them and queues commands.
// Depends on wchs_pkg.
`default_nettype none
module wchs_front #(
    parameter int FFT_SIZE = wchs_pkg::FFT_SIZE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [111:0]         s_tdata,   // bin, u_re, u_im, y_re, y_im, zero pad
    input  wire logic [1:0]           s_tuser,   // kind
    input  wire logic                 hold_in,
    output logic                      q_valid,
    output wchs_pkg::qent_t           q_data,
    input  wire logic                 q_pop
);
    import wchs_pkg::*;

    localparam logic [31:0] LAST_BIN = 32'(FFT_SIZE / 2);

    qent_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    logic [BIN_W-1:0] bin;
    logic [31:0]      bin32;
    logic             in_range, enq, push;
    qent_t            ent;

    assign bin      = s_tdata[9:0];
    assign bin32    = {22'd0, bin};
    assign in_range = bin32 <= LAST_BIN;

    // classify the beat
    always_comb begin
        ent.bin      = bin;
        ent.seg_end  = bin32 == LAST_BIN;
        ent.band_end = (bin32 == LAST_BIN) || (bin32 == 32'd0);
        ent.u_re     = s_tdata[33:10];
        ent.u_im     = s_tdata[57:34];
        ent.y_re     = s_tdata[81:58];
        ent.y_im     = s_tdata[105:82];
        ent.cmd      = CMD_ACC;
        enq          = 1'b0;
        case (s_tuser)
            KIND_ACC: begin
                enq = in_range;
            end
            KIND_READ: begin
                enq     = 1'b1;
                ent.cmd = in_range ? CMD_READ : CMD_READ_OOR;
            end
            KIND_CLEAR: begin
                enq     = 1'b1;
                ent.cmd = CMD_CLEAR;
            end
            default: begin
                enq = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != (QPTR_W+1)'(QDEPTH)) && !hold_in;
    assign push     = s_tvalid && s_tready && enq;
    assign q_valid  = cnt_reg != '0;
    assign q_data   = q_reg[rp_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= ent;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
        end
    end

endmodule
`default_nettype wire

[sv/wchs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the averaging, gain and coherence steps of a read.
// Depends on wchs_pkg.
`default_nettype none
module wchs_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [127:0] rem_in,
    input  wire logic [127:0] shin_in,
    input  wire logic [127:0] den_in,
    input  wire logic [6:0]   iters,
    output logic              done,
    output logic [79:0]       quo
);
    import wchs_pkg::*;

    logic [127:0] rem_reg, shin_reg, den_reg;
    logic [79:0]  quo_reg;
    logic [6:0]   cnt_reg;
    logic         run_reg, done_reg;

    logic [128:0] trial, diff;
    logic         ge;

    // one trial subtraction
    assign trial = {rem_reg, shin_reg[127]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_in;
            shin_reg <= shin_in;
            den_reg  <= den_in;
            quo_reg  <= '0;
        end else if (run_reg) begin
            rem_reg  <= ge ? diff[127:0] : trial[127:0];
            shin_reg <= {shin_reg[126:0], 1'b0};
            quo_reg  <= {quo_reg[78:0], ge};
        end
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= iters;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[sv/wchs_back.sv]
// Back end: bin memories, accumulate datapath and the read sequencer.
// Depends on wchs_pkg and wchs_div.
`default_nettype none
module wchs_back #(
    parameter int FFT_SIZE = wchs_pkg::FFT_SIZE_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire wchs_pkg::qent_t q_data,
    output logic                 q_pop,
    output logic                 init_busy,
    input  wire logic [23:0]     scale,
    input  wire logic [31:0]     regz,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          gain_re,
    output logic [31:0]          gain_im,
    output logic [16:0]          coherence,
    output logic [15:0]          segments
);
    import wchs_pkg::*;

    localparam int NBINS = FFT_SIZE / 2 + 1;
    localparam int AW    = $clog2(NBINS);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_ACC1, S_ACC2, S_ACC3, S_RD0, S_RD1,
        S_AVG, S_AVGW, S_SUU, S_MUL, S_G0, S_G0W, S_G1, S_G1W, S_COH, S_COHW, S_OUT
    } state_t;

    state_t state_reg;
    qent_t  cur_reg;

    // bin memories
    logic signed [63:0] mem_uu [NBINS];
    logic signed [63:0] mem_yy [NBINS];
    logic signed [63:0] mem_re [NBINS];
    logic signed [63:0] mem_im [NBINS];
    logic signed [63:0] rd_uu_reg, rd_yy_reg, rd_re_reg, rd_im_reg;

    logic [AW-1:0] sweep_reg, addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [63:0] wr_uu, wr_yy, wr_re, wr_im;

    logic [15:0] seg_reg;

    // accumulate pipeline
    logic signed [23:0] ur_reg, ui_reg, yr_reg, yi_reg;
    logic signed [47:0] p_uu1_reg, p_uu2_reg, p_yy1_reg, p_yy2_reg;
    logic signed [47:0] p_re1_reg, p_re2_reg, p_im1_reg, p_im2_reg;
    logic signed [48:0] d_uu, d_yy, d_re, d_im;
    logic signed [48:0] q_uu, q_yy, q_re, q_im;
    logic signed [48:0] sc_ur, sc_ui, sc_yr, sc_yi;

    // read sequence
    logic signed [63:0] sum_reg [4];
    logic signed [63:0] avg_reg [4];
    logic [1:0]         k_reg;
    logic [63:0]        suu_reg, syyp_reg, mre_reg, mim_reg;
    logic [3:0]         mk_reg;
    logic [63:0]        prod_reg;
    logic               pv_reg, pnum_reg;
    logic [1:0]         psh_reg;
    logic [127:0]       num_reg, den_reg, prod_ext;
    logic [31:0]        gre_reg, gim_reg;
    logic [16:0]        coh_reg;
    logic [63:0]        opa, opb;
    logic [31:0]        opa_part, opb_part;

    logic [31:0]  res_gre_reg, res_gim_reg;
    logic [16:0]  res_coh_reg;
    logic [15:0]  res_seg_reg;
    logic         m_valid_reg;

    // divider hookup
    logic         div_start, div_done;
    logic [127:0] div_rem, div_shin, div_den;
    logic [6:0]   div_iters;
    logic [79:0]  div_quo;
    logic [15:0]  cnt_div;

    function automatic logic signed [48:0] ur_mul(input logic signed [23:0] v);
        ur_mul = v * $signed({1'b0, scale});
    endfunction

    wchs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .rem_in  (div_rem),
        .shin_in (div_shin),
        .den_in  (div_den),
        .iters   (div_iters),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign addr      = AW'({22'd0, cur_reg.bin});
    assign init_busy = state_reg == S_INIT;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign cnt_div   = (seg_reg == 16'd0) ? 16'd1 : seg_reg;

    assign m_tvalid  = m_valid_reg;
    assign gain_re   = res_gre_reg;
    assign gain_im   = res_gim_reg;
    assign coherence = res_coh_reg;
    assign segments  = res_seg_reg;

    // scale the spectra
    assign sc_ur = ur_mul(q_data.u_re);
    assign sc_ui = ur_mul(q_data.u_im);
    assign sc_yr = ur_mul(q_data.y_re);
    assign sc_yi = ur_mul(q_data.y_im);

    // power and cross terms, quartered at DC and Nyquist
    assign d_uu = 49'(p_uu1_reg) + 49'(p_uu2_reg);
    assign d_yy = 49'(p_yy1_reg) + 49'(p_yy2_reg);
    assign d_re = 49'(p_re1_reg) + 49'(p_re2_reg);
    assign d_im = 49'(p_im1_reg) - 49'(p_im2_reg);
    assign q_uu = cur_reg.band_end ? (d_uu >>> 2) : d_uu;
    assign q_yy = cur_reg.band_end ? (d_yy >>> 2) : d_yy;
    assign q_re = cur_reg.band_end ? (d_re >>> 2) : d_re;
    assign q_im = cur_reg.band_end ? (d_im >>> 2) : d_im;

    // memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_uu   = sat_add(rd_uu_reg, q_uu);
        wr_yy   = sat_add(rd_yy_reg, q_yy);
        wr_re   = sat_add(rd_re_reg, q_re);
        wr_im   = sat_add(rd_im_reg, q_im);
        if (state_reg == S_INIT || state_reg == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_uu   = '0;
            wr_yy   = '0;
            wr_re   = '0;
            wr_im   = '0;
        end else if (state_reg == S_ACC3) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_uu[wr_addr] <= wr_uu;
            mem_yy[wr_addr] <= wr_yy;
            mem_re[wr_addr] <= wr_re;
            mem_im[wr_addr] <= wr_im;
        end
        rd_uu_reg <= mem_uu[addr];
        rd_yy_reg <= mem_yy[addr];
        rd_re_reg <= mem_re[addr];
        rd_im_reg <= mem_im[addr];
    end

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_rem   = '0;
        div_shin  = '0;
        div_den   = {64'd0, suu_reg};
        div_iters = 7'd80;
        case (state_reg)
            S_AVG: begin
                div_start = 1'b1;
                div_shin  = {mag64(sum_reg[k_reg]), 64'd0};
                div_den   = {112'd0, cnt_div};
                div_iters = 7'd64;
            end
            S_G0: begin
                div_start = suu_reg != '0;
                div_shin  = {mre_reg, 64'd0};
            end
            S_G1: begin
                div_start = 1'b1;
                div_shin  = {mim_reg, 64'd0};
            end
            S_COH: begin
                div_start = (den_reg != '0) && (num_reg < den_reg);
                div_rem   = num_reg;
                div_den   = den_reg;
                div_iters = 7'd16;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // partial product operands: four 32x32 products per 64x64 product
    always_comb begin
        case (mk_reg[3:2])
            2'd0: begin
                opa = mre_reg;
                opb = mre_reg;
            end
            2'd1: begin
                opa = mim_reg;
                opb = mim_reg;
            end
            default: begin
                opa = suu_reg;
                opb = syyp_reg;
            end
        endcase
        opa_part = mk_reg[1] ? opa[63:32] : opa[31:0];
        opb_part = mk_reg[0] ? opb[63:32] : opb[31:0];
        case (psh_reg)
            2'd0:    prod_ext = {64'd0, prod_reg};
            2'd1:    prod_ext = {32'd0, prod_reg, 32'd0};
            default: prod_ext = {prod_reg, 64'd0};
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            sweep_reg   <= '0;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            // drop the result beat once taken; the output step reloads it itself
            if (m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT, S_CLR: begin
                    seg_reg <= '0;
                    if (sweep_reg == AW'(NBINS - 1)) begin
                        sweep_reg <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cur_reg <= q_data;
                        ur_reg  <= sc_ur[47:24];
                        ui_reg  <= sc_ui[47:24];
                        yr_reg  <= sc_yr[47:24];
                        yi_reg  <= sc_yi[47:24];
                        case (q_data.cmd)
                            CMD_ACC:   state_reg <= S_ACC1;
                            CMD_READ:  state_reg <= S_RD0;
                            CMD_CLEAR: state_reg <= S_CLR;
                            default: begin
                                gre_reg   <= '0;
                                gim_reg   <= '0;
                                coh_reg   <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_ACC1: begin
                    p_uu1_reg <= ur_reg * ur_reg;
                    p_uu2_reg <= ui_reg * ui_reg;
                    p_yy1_reg <= yr_reg * yr_reg;
                    p_yy2_reg <= yi_reg * yi_reg;
                    p_re1_reg <= yr_reg * ur_reg;
                    p_re2_reg <= yi_reg * ui_reg;
                    p_im1_reg <= yi_reg * ur_reg;
                    p_im2_reg <= yr_reg * ui_reg;
                    state_reg <= S_ACC2;
                end
                S_ACC2: begin
                    state_reg <= S_ACC3;
                end
                S_ACC3: begin
                    if (cur_reg.seg_end && seg_reg != 16'hFFFF) begin
                        seg_reg <= seg_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_RD0: begin
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    sum_reg[0] <= rd_uu_reg;
                    sum_reg[1] <= rd_yy_reg;
                    sum_reg[2] <= rd_re_reg;
                    sum_reg[3] <= rd_im_reg;
                    k_reg      <= '0;
                    state_reg  <= S_AVG;
                end
                S_AVG: begin
                    state_reg <= S_AVGW;
                end
                S_AVGW: begin
                    if (div_done) begin
                        avg_reg[k_reg] <= sum_reg[k_reg][63] ? 64'(-div_quo[63:0])
                                                             : div_quo[63:0];
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == 2'd3) ? S_SUU : S_AVG;
                    end
                end
                S_SUU: begin
                    suu_reg   <= (avg_reg[0] > 0 ? avg_reg[0] : 64'd0) + {32'd0, regz};
                    syyp_reg  <= avg_reg[1] > 0 ? avg_reg[1] : 64'd0;
                    mre_reg   <= mag64(avg_reg[2]);
                    mim_reg   <= mag64(avg_reg[3]);
                    mk_reg    <= '0;
                    num_reg   <= '0;
                    den_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    // issue one partial product, add the previous one
                    pv_reg   <= mk_reg != 4'd12;
                    prod_reg <= opa_part * opb_part;
                    pnum_reg <= mk_reg < 4'd8;
                    psh_reg  <= 2'(mk_reg[1]) + 2'(mk_reg[0]);
                    mk_reg   <= mk_reg + 1'b1;
                    if (pv_reg) begin
                        if (pnum_reg) begin
                            num_reg <= num_reg + prod_ext;
                        end else begin
                            den_reg <= den_reg + prod_ext;
                        end
                    end
                    if (mk_reg == 4'd12) begin
                        state_reg <= S_G0;
                    end
                end
                S_G0: begin
                    if (suu_reg == '0) begin
                        gre_reg   <= '0;
                        gim_reg   <= '0;
                        state_reg <= S_COH;
                    end else begin
                        state_reg <= S_G0W;
                    end
                end
                S_G0W: begin
                    if (div_done) begin
                        gre_reg   <= gain_fix(div_quo, avg_reg[2][63]);
                        state_reg <= S_G1;
                    end
                end
                S_G1: begin
                    state_reg <= S_G1W;
                end
                S_G1W: begin
                    if (div_done) begin
                        gim_reg   <= gain_fix(div_quo, avg_reg[3][63]);
                        state_reg <= S_COH;
                    end
                end
                S_COH: begin
                    if (den_reg == '0) begin
                        coh_reg   <= '0;
                        state_reg <= S_OUT;
                    end else if (num_reg >= den_reg) begin
                        coh_reg   <= 17'd65536;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_COHW;
                    end
                end
                S_COHW: begin
                    if (div_done) begin
                        coh_reg   <= {1'b0, div_quo[15:0]};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // load the output register once it is free
                    if (!m_valid_reg || m_tready) begin
                        res_gre_reg <= gre_reg;
                        res_gim_reg <= gim_reg;
                        res_coh_reg <= coh_reg;
                        res_seg_reg <= seg_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // divider finishes only while the sequencer waits on it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_AVGW || state_reg == S_G0W ||
                      state_reg == S_G1W || state_reg == S_COHW))
        else $error("divider result with no step waiting");

    // segment count steps by one or clears
    a_seg_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_reg != $past(seg_reg)) |->
            (seg_reg == $past(seg_reg) + 16'd1 || seg_reg == 16'd0))
        else $error("segment count jumped");

    // a new result beat is loaded only from the output step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_OUT && !m_valid_reg) |=> !m_valid_reg)
        else $error("result beat raised outside output step");

    // no item is taken from the queue during the clearing sweep
    a_no_pop_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT || state_reg == S_CLR) |-> !q_pop)
        else $error("queue popped during clear");

endmodule
`default_nettype wire

[sv/welch_cross_spectrum_h1.sv]
// Welch cross-spectrum accumulator with H1 gain and coherence readout.
// An accumulate beat goes through the back end in steps (queue pop, scaling,
// products, read-modify-write of the bin memories); the 4-entry queue absorbs
// short bursts. A read beat runs on the one-bit-per-cycle divider: four
// 64-bit averages, two 80-bit gain quotients and a 16-bit coherence quotient,
// plus 32x32 partial products. A clear beat and the clearing pass after reset
// each sweep all FFT_SIZE/2+1 bins (513 at the default size); s_tready stays
// low during the pass after reset.
// Depends on wchs_pkg, wchs_front, wchs_back.
`default_nettype none
module welch_cross_spectrum_h1 #(
    parameter int FFT_SIZE = wchs_pkg::FFT_SIZE_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,   // bin[9:0], u_re, u_im, y_re, y_im, zero pad
    input  wire logic [1:0]   s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // gain_re, gain_im, coherence, segments, zero pad
    input  wire logic         cfg_wen,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata
);
    import wchs_pkg::*;

    logic [23:0] scale_reg;
    logic [31:0] regz_reg;
    logic        q_valid, q_pop, init_busy;
    qent_t       q_data;
    logic [31:0] gain_re, gain_im;
    logic [16:0] coherence;
    logic [15:0] segments;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            regz_reg  <= REGZ_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_wdata[23:0];
                CFG_REGZ:  regz_reg  <= cfg_wdata;
                default:   regz_reg  <= regz_reg;
            endcase
        end
    end

    wchs_front #(.FFT_SIZE(FFT_SIZE)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold_in  (init_busy),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    wchs_back #(.FFT_SIZE(FFT_SIZE)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .scale     (scale_reg),
        .regz      (regz_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .gain_re   (gain_re),
        .gain_im   (gain_im),
        .coherence (coherence),
        .segments  (segments)
    );

    // pack the result beat
    assign m_tdata = {7'd0, segments, coherence, gain_im, gain_re};

endmodule
`default_nettype wire

[dv/welch_cross_spectrum_h1_tb.sv]
// Self-checking testbench for welch_cross_spectrum_h1: stream driver, result monitor and
// a bit-exact Welch accumulator/H1 predictor kept inside the bench.
// Depends on wchs_pkg and the welch_cross_spectrum_h1 RTL.
`timescale 1ns / 100ps
module welch_cross_spectrum_h1_tb;
    import wchs_pkg::*;

    localparam int NYQ       = 512;
    localparam int SETTLE    = 3000;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 2500;

    typedef struct {
        logic [1:0]         kind;
        logic [9:0]         bin;
        logic signed [23:0] u_re, u_im, y_re, y_im;
        bit                 drain;
    } spec_beat_t;

    typedef struct {
        logic [31:0] gain_re, gain_im;
        logic [16:0] coherence;
        logic [15:0] segments;
    } estimate_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_wen = 1'b0;
    logic         cfg_index = CFG_SCALE;
    logic [31:0]  cfg_wdata = '0;

    welch_cross_spectrum_h1 uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    longint signed uu_sum [0:NYQ];
    longint signed yy_sum [0:NYQ];
    longint signed xr_sum [0:NYQ];
    longint signed xi_sum [0:NYQ];
    int unsigned   seg_cnt;
    logic [23:0]   scale_q;
    logic [31:0]   delta_q;

    spec_beat_t pending_beats[$];
    estimate_t  owed_estimates[$];
    int         mismatches = 0;
    int         beats_in = 0;
    int         results_out = 0;
    bit         active = 1'b0;

    function automatic longint signed sat_sum(longint signed a, longint signed b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [31:0] h1_gain(longint signed num, logic [63:0] den);
        logic [63:0]  n;
        logic [127:0] q;
        logic [31:0]  m;
        n = num < 0 ? 64'(-num) : 64'(num);
        q = {n, 16'd0} / {64'd0, den};
        m = (q >= 128'h8000_0000) ? 32'h8000_0000 : q[31:0];
        if (num < 0) return 32'(-m);
        return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
    endfunction

    function automatic logic [16:0] msc(longint signed cr, longint signed ci,
                                        logic [63:0] suu, longint signed syy);
        logic [63:0]  crm, cim, syp;
        logic [127:0] num, den;
        logic [159:0] q;
        crm = cr < 0 ? 64'(-cr) : 64'(cr);
        cim = ci < 0 ? 64'(-ci) : 64'(ci);
        syp = syy > 0 ? 64'(syy) : 64'd0;
        num = 128'(crm) * 128'(crm) + 128'(cim) * 128'(cim);
        den = 128'(suu) * 128'(syp);
        if (den == 0) return '0;
        if (num >= den) return 17'd65536;
        q = {16'd0, num, 16'd0} / {32'd0, den};
        return q[16:0];
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i <= NYQ; i++) begin
            uu_sum[i] = 0; yy_sum[i] = 0; xr_sum[i] = 0; xi_sum[i] = 0;
        end
        seg_cnt = 0;
    endfunction

    // advance the predictor by one beat; return 1 when a result is owed
    function automatic bit welch_predict(spec_beat_t b, output estimate_t e);
        longint signed sc, ur, ui, yr, yi, duu, dyy, dre, dim, cnt, auu, ayy, are, aim;
        logic [63:0] suu;
        e = '{default: '0};
        sc = longint'(scale_q);
        if (b.kind == KIND_CLEAR) begin
            clear_sums();
            return 1'b0;
        end
        if (b.kind == KIND_ACC) begin
            if (b.bin > NYQ) return 1'b0;
            ur = (longint'(b.u_re) * sc) >>> 24;
            ui = (longint'(b.u_im) * sc) >>> 24;
            yr = (longint'(b.y_re) * sc) >>> 24;
            yi = (longint'(b.y_im) * sc) >>> 24;
            duu = ur * ur + ui * ui;
            dyy = yr * yr + yi * yi;
            dre = yr * ur + yi * ui;
            dim = yi * ur - yr * ui;
            // quarter the edge bins
            if (b.bin == 0 || b.bin == NYQ) begin
                duu = duu >>> 2; dyy = dyy >>> 2; dre = dre >>> 2; dim = dim >>> 2;
            end
            uu_sum[b.bin] = sat_sum(uu_sum[b.bin], duu);
            yy_sum[b.bin] = sat_sum(yy_sum[b.bin], dyy);
            xr_sum[b.bin] = sat_sum(xr_sum[b.bin], dre);
            xi_sum[b.bin] = sat_sum(xi_sum[b.bin], dim);
            if (b.bin == NYQ && seg_cnt < 65535) seg_cnt++;
            return 1'b0;
        end
        if (b.kind == KIND_READ) begin
            e.segments = seg_cnt[15:0];
            if (b.bin <= NYQ) begin
                cnt = seg_cnt ? longint'(seg_cnt) : 1;
                auu = uu_sum[b.bin] / cnt;
                ayy = yy_sum[b.bin] / cnt;
                are = xr_sum[b.bin] / cnt;
                aim = xi_sum[b.bin] / cnt;
                suu = (auu > 0 ? 64'(auu) : 64'd0) + 64'(delta_q);
                if (suu != 0) begin
                    e.gain_re = h1_gain(are, suu);
                    e.gain_im = h1_gain(aim, suu);
                end
                e.coherence = msc(are, aim, suu, ayy);
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [23:0] spec_val();
        case ($urandom_range(7))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return '0;
            3: return 24'($signed($urandom_range(4095)) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_beat(logic [1:0] kind, logic [9:0] bin, bit drain = 1'b0);
        spec_beat_t b;
        b.kind = kind; b.bin = bin; b.drain = drain;
        b.u_re = spec_val(); b.u_im = spec_val(); b.y_re = spec_val(); b.y_im = spec_val();
        pending_beats.push_back(b);
    endtask

    task automatic queue_fixed(logic [9:0] bin, int ur, int ui, int yr, int yi);
        spec_beat_t b;
        b.kind = KIND_ACC; b.bin = bin; b.drain = 1'b0;
        b.u_re = 24'(ur); b.u_im = 24'(ui); b.y_re = 24'(yr); b.y_im = 24'(yi);
        pending_beats.push_back(b);
    endtask

    task automatic queue_random(int count);
        int r;
        logic [9:0] bin;
        logic [1:0] kind;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: bin = 10'($urandom_range(5));
                5:             bin = 10'(NYQ);
                6:             bin = 10'($urandom_range(1023, NYQ + 1));
                7:             bin = 10'($urandom);
                default:       bin = 10'($urandom_range(NYQ));
            endcase
            if (r < 78)      kind = KIND_ACC;
            else if (r < 94) kind = KIND_READ;
            else if (r < 95) kind = KIND_CLEAR;
            else             kind = KIND_UNUSED;
            queue_beat(kind, bin, $urandom_range(49) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || owed_estimates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_SCALE) scale_q = val[23:0];
        else                  delta_q = val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %h expected %h", results_out, what, got, want);
    endtask

    // stimulus sequence
    initial begin
        clear_sums();
        scale_q = SCALE_RESET;
        delta_q = REGZ_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        active = 1'b1;

        // directed: edges, cross terms, saturation of the gain, empty and far bins
        queue_fixed(0, -8388608, 8388607, -8388608, 8388607);
        queue_fixed(NYQ, 8388607, -8388608, 8388607, -8388608);
        queue_fixed(7, 256, 0, 8388607, 0);
        queue_fixed(8, 256, 0, -8388608, 0);
        queue_fixed(1, 4096, -4096, -2048, 8192);
        queue_fixed(1000, 8388607, 8388607, 8388607, 8388607);
        queue_beat(KIND_READ, 0);
        queue_beat(KIND_READ, NYQ);
        queue_beat(KIND_READ, 7);
        queue_beat(KIND_READ, 8);
        queue_beat(KIND_READ, 1);
        queue_beat(KIND_READ, 3);
        queue_beat(KIND_READ, 1000);
        queue_beat(KIND_READ, 10'h3FF);
        queue_beat(KIND_UNUSED, 1);
        queue_beat(KIND_CLEAR, 0, 1'b1);
        queue_beat(KIND_READ, 0);
        queue_beat(KIND_READ, 1);
        queue_random(220);
        wait_drained();

        write_reg(CFG_SCALE, 32'hFF_FFFF);
        write_reg(CFG_REGZ, 32'd0);
        queue_random(260);
        wait_drained();

        write_reg(CFG_SCALE, 32'd0);
        write_reg(CFG_REGZ, 32'hFFFF_FFFF);
        queue_random(150);
        wait_drained();

        write_reg(CFG_SCALE, 32'($urandom_range(24'hFF_FFFF)));
        write_reg(CFG_REGZ, 32'($urandom_range(4095)));
        queue_random(300);
        wait_drained();

        write_reg(CFG_SCALE, 32'h80_0000);
        write_reg(CFG_REGZ, $urandom);
        queue_random(300);
        wait_drained();

        if (mismatches == 0) begin
            $display("welch_cross_spectrum_h1_tb passed");
        end else begin
            $display("welch_cross_spectrum_h1_tb failed");
        end
        $finish;
    end

    // input driver: predict on each accepted beat, then offer the next one
    always @(posedge aclk) begin
        spec_beat_t nb;
        estimate_t  est;
        bit         quiet, hold;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                nb.kind = s_tuser; nb.bin = s_tdata[9:0];
                nb.u_re = s_tdata[33:10]; nb.u_im = s_tdata[57:34];
                nb.y_re = s_tdata[81:58]; nb.y_im = s_tdata[105:82];
                if (welch_predict(nb, est)) owed_estimates.push_back(est);
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                quiet = beats_in >= 400 && beats_in < 600;
                hold  = pending_beats.size() == 0 || !active ||
                        (pending_beats[0].drain && owed_estimates.size() != 0) ||
                        (!quiet && $urandom_range(99) < 18);
                if (hold) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nb = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nb.kind;
                    s_tdata  <= {6'd0, nb.y_im, nb.y_re, nb.u_im, nb.u_re, nb.bin};
                end
            end
        end
    end

    // result monitor with one long hold-off to back up the block
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        estimate_t want;
        bit        quiet;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_out++;
                if (owed_estimates.size() == 0) begin
                    report("unowed result gain_re", m_tdata[31:0], '0);
                end else begin
                    want = owed_estimates.pop_front();
                    if (m_tdata[31:0] !== want.gain_re)
                        report("gain_re", m_tdata[31:0], want.gain_re);
                    if (m_tdata[63:32] !== want.gain_im)
                        report("gain_im", m_tdata[63:32], want.gain_im);
                    if (m_tdata[80:64] !== want.coherence)
                        report("coherence", 32'(m_tdata[80:64]), 32'(want.coherence));
                    if (m_tdata[96:81] !== want.segments)
                        report("segments", 32'(m_tdata[96:81]), 32'(want.segments));
                end
            end
            if (!hold_done && results_out == 12) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            quiet = beats_in >= 400 && beats_in < 600;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || $urandom_range(99) >= 18;
            end
        end
    end

    // watchdog on cycles without any accepted input or result beat or configuration write
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("welch_cross_spectrum_h1_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
